@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL of the fan remote command retry controller.
// Each macro checks one implication on the rising clock edge, skipped during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ hw/rtl/frc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_pkg
// Types and codes shared by the fan remote command retry controller modules.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned FRAME_W = 24;
  localparam int unsigned CODE_W  = 4;

  // Request modes.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_FRAME   = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  // Command requests.
  localparam logic [2:0] REQ_NONE   = 3'd0;
  localparam logic [2:0] REQ_ON     = 3'd1;
  localparam logic [2:0] REQ_OFF    = 3'd2;
  localparam logic [2:0] REQ_SUMMER = 3'd3;
  localparam logic [2:0] REQ_SLOW   = 3'd4;
  localparam logic [2:0] REQ_MIDDLE = 3'd5;
  localparam logic [2:0] REQ_FAST   = 3'd6;

  // Events reported with each result.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_DONE     = 3'd2;
  localparam logic [2:0] EV_FAILED   = 3'd3;
  localparam logic [2:0] EV_NOT_POSS = 3'd4;

  // Status codes carried in the low nibble of a frame.
  localparam logic [3:0] ST_OFF      = 4'h0;
  localparam logic [3:0] ST_SLOW_IN  = 4'h6;
  localparam logic [3:0] ST_SLOW_OUT = 4'h7;
  localparam logic [3:0] ST_MID_IN   = 4'hA;
  localparam logic [3:0] ST_MID_OUT  = 4'hB;
  localparam logic [3:0] ST_FAST_IN  = 4'hC;
  localparam logic [3:0] ST_FAST_OUT = 4'hD;
  localparam logic [3:0] ST_SUMMER   = 4'hE;

  // Button codes carried in the low nibble of a frame.
  localparam logic [3:0] BTN_NONE   = 4'h0;
  localparam logic [3:0] BTN_SUMMER = 4'h1;
  localparam logic [3:0] BTN_MINUS  = 4'h2;
  localparam logic [3:0] BTN_PLUS   = 4'h4;
  localparam logic [3:0] BTN_POWER  = 4'h8;

  // Reported button index.
  localparam logic [2:0] SEEN_NONE   = 3'd0;
  localparam logic [2:0] SEEN_POWER  = 3'd1;
  localparam logic [2:0] SEEN_SUMMER = 3'd2;
  localparam logic [2:0] SEEN_PLUS   = 3'd3;
  localparam logic [2:0] SEEN_MINUS  = 3'd4;

  // Decoded fan mode, speed and direction.
  localparam logic [1:0] FM_OFF      = 2'd0;
  localparam logic [1:0] FM_INTERVAL = 2'd1;
  localparam logic [1:0] FM_SUMMER   = 2'd2;
  localparam logic [1:0] SPD_NONE    = 2'd0;
  localparam logic [1:0] SPD_SLOW    = 2'd1;
  localparam logic [1:0] SPD_MIDDLE  = 2'd2;
  localparam logic [1:0] SPD_FAST    = 2'd3;
  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_IN      = 2'd1;
  localparam logic [1:0] DIR_OUT     = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_FAN_ADDRESS   = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [19:0] FAN_ADDRESS_RST   = 20'd584198;
  localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;

  typedef struct packed {
    logic [19:0] fan_address;
    logic [3:0]  retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] received_frame;
    logic [2:0]  request;
  } item_t;

  typedef struct packed {
    logic        transmit;
    logic [23:0] transmit_frame;
    logic [2:0]  event_res;
    logic [1:0]  fan_mode;
    logic [1:0]  fan_speed;
    logic [1:0]  fan_direction;
    logic [2:0]  button_seen;
    logic [15:0] failure_count;
    logic        busy_res;
  } res_t;

endpackage

@@ hw/rtl/fan_remote_command_retry_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_remote_command_retry_controller
// Sends fan remote button frames, waits for a confirming status, resends on
// timeout and counts failed commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    mode, received_frame, request
// out_      output     out_valid / out_ready  transmit ... busy_res
// cfg_      input      cfg_write_en           cfg_index, cfg_data
//
// One request is taken every cycle while the result side does not stall; its result
// passes the input register, then the result register after the status logic.
// The output register lets a new request enter while a result waits.
// Reset is synchronous; there is no clearing pass.
// A result-side stall holds both registers and drops in_ready once the input is full.
// ----------------------------------------------------------------------------
module fan_remote_command_retry_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_received_frame,
  input  logic [2:0]  in_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_transmit,
  output logic [23:0] out_transmit_frame,
  output logic [2:0]  out_event_res,
  output logic [1:0]  out_fan_mode,
  output logic [1:0]  out_fan_speed,
  output logic [1:0]  out_fan_direction,
  output logic [2:0]  out_button_seen,
  output logic [15:0] out_failure_count,
  output logic        out_busy_res,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  frc_pkg::cfg_t  cfg_r;
  frc_pkg::item_t item_r;
  frc_pkg::res_t  res;
  frc_pkg::res_t  res_r;
  logic           in_vld_r, in_vld_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fan_address   <= frc_pkg::FAN_ADDRESS_RST;
      cfg_r.retry_limit   <= frc_pkg::RETRY_LIMIT_RST;
      cfg_r.timeout_ticks <= frc_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        frc_pkg::CFG_FAN_ADDRESS:   cfg_r.fan_address   <= cfg_data;
        frc_pkg::CFG_RETRY_LIMIT:   cfg_r.retry_limit   <= cfg_data[3:0];
        frc_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready    = !in_vld_r || advance;
  assign in_vld_nxt  = (in_valid && in_ready) || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode           <= in_mode;
      item_r.received_frame <= in_received_frame;
      item_r.request        <= in_request;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  frc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid          = out_vld_r;
  assign out_transmit       = res_r.transmit;
  assign out_transmit_frame = res_r.transmit_frame;
  assign out_event_res      = res_r.event_res;
  assign out_fan_mode       = res_r.fan_mode;
  assign out_fan_speed      = res_r.fan_speed;
  assign out_fan_direction  = res_r.fan_direction;
  assign out_button_seen    = res_r.button_seen;
  assign out_failure_count  = res_r.failure_count;
  assign out_busy_res       = res_r.busy_res;

endmodule

@@ hw/rtl/frc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_core
// Command, status and retry state of the fan link, updated once per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  frc_pkg::item_t item,
  input  frc_pkg::cfg_t  cfg,
  output frc_pkg::res_t  res
);

  localparam logic PH_WAIT = 1'b0;
  localparam logic PH_BUSY = 1'b1;

  function automatic logic is_slow(input logic [3:0] s);
    return (s == frc_pkg::ST_SLOW_IN) || (s == frc_pkg::ST_SLOW_OUT);
  endfunction

  function automatic logic is_mid(input logic [3:0] s);
    return (s == frc_pkg::ST_MID_IN) || (s == frc_pkg::ST_MID_OUT);
  endfunction

  function automatic logic is_fast(input logic [3:0] s);
    return (s == frc_pkg::ST_FAST_IN) || (s == frc_pkg::ST_FAST_OUT);
  endfunction

  function automatic logic is_button(input logic [3:0] c);
    return (c == frc_pkg::BTN_SUMMER) || (c == frc_pkg::BTN_MINUS) ||
           (c == frc_pkg::BTN_PLUS) || (c == frc_pkg::BTN_POWER);
  endfunction

  // Decoded status layout: [1:0] mode, [3:2] speed, [5:4] direction.
  function automatic logic [5:0] decode(input logic [3:0] s, input logic [5:0] prev);
    logic [5:0] d;
    d = prev;
    if (s == frc_pkg::ST_OFF) begin
      d = {frc_pkg::DIR_NONE, frc_pkg::SPD_NONE, frc_pkg::FM_OFF};
    end else if (s == frc_pkg::ST_SUMMER) begin
      d = {frc_pkg::DIR_OUT, frc_pkg::SPD_SLOW, frc_pkg::FM_SUMMER};
    end else if (is_slow(s) || is_mid(s) || is_fast(s)) begin
      d[1:0] = frc_pkg::FM_INTERVAL;
      d[5:4] = s[0] ? frc_pkg::DIR_OUT : frc_pkg::DIR_IN;
      d[3:2] = is_fast(s) ? frc_pkg::SPD_FAST :
               (is_mid(s) ? frc_pkg::SPD_MIDDLE : frc_pkg::SPD_SLOW);
    end
    return d;
  endfunction

  function automatic logic [2:0] button_index(input logic [3:0] b);
    logic [2:0] idx;
    case (b)
      frc_pkg::BTN_POWER:  idx = frc_pkg::SEEN_POWER;
      frc_pkg::BTN_SUMMER: idx = frc_pkg::SEEN_SUMMER;
      frc_pkg::BTN_PLUS:   idx = frc_pkg::SEEN_PLUS;
      frc_pkg::BTN_MINUS:  idx = frc_pkg::SEEN_MINUS;
      default:             idx = frc_pkg::SEEN_NONE;
    endcase
    return idx;
  endfunction

  logic        phase_r,    phase_nxt;
  logic [2:0]  pend_req_r, pend_req_nxt;
  logic [3:0]  pend_btn_r, pend_btn_nxt;
  logic [3:0]  resend_r,   resend_nxt;
  logic [15:0] timer_r,    timer_nxt;
  logic [3:0]  status_r,   status_nxt;
  logic [3:0]  button_r,   button_nxt;
  logic [5:0]  decoded_r,  decoded_nxt;
  logic [15:0] failures_r, failures_nxt;

  logic        tx;
  logic [2:0]  evt;
  logic        timed_out;
  logic        confirmed;
  logic [2:0]  new_req;
  logic [3:0]  new_btn;
  logic [15:0] timer_inc;

  always_comb begin
    phase_nxt    = phase_r;
    pend_req_nxt = pend_req_r;
    pend_btn_nxt = pend_btn_r;
    resend_nxt   = resend_r;
    timer_nxt    = timer_r;
    status_nxt   = status_r;
    button_nxt   = button_r;
    failures_nxt = failures_r;
    tx           = 1'b0;
    evt          = frc_pkg::EV_NONE;
    timed_out    = 1'b0;
    confirmed    = 1'b0;
    new_req      = frc_pkg::REQ_NONE;
    new_btn      = frc_pkg::BTN_NONE;
    timer_inc    = (timer_r != 16'hFFFF) ? timer_r + 16'd1 : timer_r;

    case (item.mode)
      frc_pkg::MODE_FRAME: begin
        if (item.received_frame[23:4] == cfg.fan_address) begin
          if (is_button(item.received_frame[3:0])) begin
            button_nxt = item.received_frame[3:0];
          end else begin
            status_nxt = item.received_frame[3:0];
          end
        end
      end
      frc_pkg::MODE_REQUEST: begin
        case (item.request)
          frc_pkg::REQ_ON: begin
            if (status_r == frc_pkg::ST_OFF) begin
              new_req = frc_pkg::REQ_ON;
              new_btn = frc_pkg::BTN_POWER;
            end
          end
          frc_pkg::REQ_OFF: begin
            if (status_r != frc_pkg::ST_OFF) begin
              new_req = frc_pkg::REQ_OFF;
              new_btn = frc_pkg::BTN_POWER;
            end
          end
          frc_pkg::REQ_SUMMER: begin
            if (status_r == frc_pkg::ST_OFF) begin
              evt = frc_pkg::EV_NOT_POSS;
            end else if (status_r != frc_pkg::ST_SUMMER) begin
              new_req = frc_pkg::REQ_SUMMER;
              new_btn = frc_pkg::BTN_SUMMER;
            end
          end
          frc_pkg::REQ_SLOW: begin
            if (status_r == frc_pkg::ST_OFF) begin
              evt = frc_pkg::EV_NOT_POSS;
            end else if (is_mid(status_r) || is_fast(status_r) ||
                         status_r == frc_pkg::ST_SUMMER) begin
              new_req = frc_pkg::REQ_SLOW;
              new_btn = frc_pkg::BTN_MINUS;
            end
          end
          frc_pkg::REQ_MIDDLE: begin
            // From summer the fan first drops to slow, so plus is pressed and slow awaited.
            if (status_r == frc_pkg::ST_OFF) begin
              evt = frc_pkg::EV_NOT_POSS;
            end else if (status_r == frc_pkg::ST_SUMMER) begin
              new_req = frc_pkg::REQ_SLOW;
              new_btn = frc_pkg::BTN_PLUS;
            end else if (is_slow(status_r)) begin
              new_req = frc_pkg::REQ_MIDDLE;
              new_btn = frc_pkg::BTN_PLUS;
            end else if (is_fast(status_r)) begin
              new_req = frc_pkg::REQ_MIDDLE;
              new_btn = frc_pkg::BTN_MINUS;
            end
          end
          frc_pkg::REQ_FAST: begin
            if (status_r == frc_pkg::ST_OFF) begin
              evt = frc_pkg::EV_NOT_POSS;
            end else if (is_mid(status_r) || is_slow(status_r) ||
                         status_r == frc_pkg::ST_SUMMER) begin
              new_req = frc_pkg::REQ_FAST;
              new_btn = frc_pkg::BTN_PLUS;
            end
          end
          default: ;
        endcase
        if (new_req != frc_pkg::REQ_NONE) begin
          pend_req_nxt = new_req;
          pend_btn_nxt = new_btn;
          if (phase_r == PH_WAIT) begin
            phase_nxt  = PH_BUSY;
            timer_nxt  = 16'd0;
            resend_nxt = 4'd0;
            tx         = 1'b1;
            evt        = frc_pkg::EV_STARTED;
          end
        end
      end
      frc_pkg::MODE_TICK: begin
        if (phase_r == PH_BUSY) begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.timeout_ticks) begin
            timed_out = 1'b1;
            timer_nxt = 16'd0;
            if (resend_r < cfg.retry_limit) begin
              resend_nxt = resend_r + 4'd1;
              tx         = 1'b1;
            end else begin
              if (failures_r != 16'hFFFF) begin
                failures_nxt = failures_r + 16'd1;
              end
              phase_nxt    = PH_WAIT;
              pend_req_nxt = frc_pkg::REQ_NONE;
              pend_btn_nxt = frc_pkg::BTN_NONE;
              resend_nxt   = 4'd0;
              evt          = frc_pkg::EV_FAILED;
            end
          end
        end
      end
      default: ;
    endcase

    // A confirming status is looked for only on tick and frame requests.
    case (pend_req_r)
      frc_pkg::REQ_ON:     confirmed = (status_nxt != frc_pkg::ST_OFF);
      frc_pkg::REQ_OFF:    confirmed = (status_nxt == frc_pkg::ST_OFF);
      frc_pkg::REQ_SUMMER: confirmed = (status_nxt == frc_pkg::ST_SUMMER);
      frc_pkg::REQ_SLOW:   confirmed = is_slow(status_nxt);
      frc_pkg::REQ_MIDDLE: confirmed = is_mid(status_nxt);
      frc_pkg::REQ_FAST:   confirmed = is_fast(status_nxt);
      default:             confirmed = 1'b0;
    endcase

    if ((item.mode == frc_pkg::MODE_TICK || item.mode == frc_pkg::MODE_FRAME) &&
        phase_r == PH_BUSY && !timed_out && confirmed) begin
      phase_nxt    = PH_WAIT;
      pend_req_nxt = frc_pkg::REQ_NONE;
      pend_btn_nxt = frc_pkg::BTN_NONE;
      resend_nxt   = 4'd0;
      timer_nxt    = 16'd0;
      evt          = frc_pkg::EV_DONE;
    end

    decoded_nxt = decode(status_nxt, decoded_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      pend_req_r <= frc_pkg::REQ_NONE;
      pend_btn_r <= frc_pkg::BTN_NONE;
      resend_r   <= 4'd0;
      timer_r    <= 16'd0;
      status_r   <= frc_pkg::ST_OFF;
      button_r   <= frc_pkg::BTN_NONE;
      decoded_r  <= 6'd0;
      failures_r <= 16'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      pend_req_r <= pend_req_nxt;
      pend_btn_r <= pend_btn_nxt;
      resend_r   <= resend_nxt;
      timer_r    <= timer_nxt;
      status_r   <= status_nxt;
      button_r   <= button_nxt;
      decoded_r  <= decoded_nxt;
      failures_r <= failures_nxt;
    end
  end

  always_comb begin
    res.transmit       = tx;
    res.transmit_frame = tx ? {cfg.fan_address, pend_btn_nxt} : 24'd0;
    res.event_res      = evt;
    res.fan_mode       = decoded_nxt[1:0];
    res.fan_speed      = decoded_nxt[3:2];
    res.fan_direction  = decoded_nxt[5:4];
    res.button_seen    = button_index(button_nxt);
    res.failure_count  = failures_nxt;
    res.busy_res       = phase_nxt;
  end

  `ASSERT_IMPLIES(a_tx_leaves_busy, clk, rst_n, step_en && res.transmit, res.busy_res)
  `ASSERT_IMPLIES(a_busy_has_request, clk, rst_n, phase_r == PH_BUSY,
                  pend_req_r != frc_pkg::REQ_NONE)
  `ASSERT_IMPLIES(a_idle_timer_clear, clk, rst_n, phase_r == PH_WAIT,
                  timer_r == 16'd0 && resend_r == 4'd0)
  `ASSERT_NEXT(a_fail_counts, clk, rst_n,
               step_en && res.event_res == frc_pkg::EV_FAILED && failures_r != 16'hFFFF,
               failures_r == $past(failures_r) + 16'd1)

endmodule

@@ sim/fan_remote_command_retry_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_remote_command_retry_controller_tb
// Self-checking bench for the fan remote command retry controller. A tracker
// class mirrors the command, retry and status-decode state and predicts every
// result. Directed requests cover the special cases first, then random phases
// under several register settings and idle patterns run the bulk of the traffic.
// ----------------------------------------------------------------------------
module fan_remote_command_retry_controller_tb;

  // Codes that the package does not name.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REQ_UNUSED  = 3'd7;
  localparam logic [3:0] ST_UNKNOWN  = 4'h3;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_ITEMS  = 220;
  localparam int FIRST_ITEMS  = 150;
  localparam int PRINT_LIMIT  = 40;

  class fan_cmd_tracker;
    logic [19:0]    addr;
    logic [3:0]     retry_max;
    logic [15:0]    tmo;
    bit             awaiting;
    logic [2:0]     target_req;
    logic [3:0]     target_btn;
    logic [3:0]     resends_used;
    logic [15:0]    tick_count;
    logic [3:0]     last_status;
    logic [3:0]     last_button;
    logic [1:0]     cur_mode;
    logic [1:0]     cur_speed;
    logic [1:0]     cur_dir;
    logic [15:0]    fail_total;
    frc_pkg::res_t  expected_q[$];
    int             mismatches;
    int             checked;
    int             n_requests;
    int             n_sent;
    int             n_done;
    int             n_failed;
    int             n_refused;

    function new();
      addr        = frc_pkg::FAN_ADDRESS_RST;
      retry_max   = frc_pkg::RETRY_LIMIT_RST;
      tmo         = frc_pkg::TIMEOUT_TICKS_RST;
      drop_command();
      last_status = frc_pkg::ST_OFF;
      last_button = frc_pkg::BTN_NONE;
      cur_mode    = frc_pkg::FM_OFF;
      cur_speed   = frc_pkg::SPD_NONE;
      cur_dir     = frc_pkg::DIR_NONE;
      fail_total  = '0;
      mismatches  = 0;
      checked     = 0;
      n_requests  = 0;
      n_sent      = 0;
      n_done      = 0;
      n_failed    = 0;
      n_refused   = 0;
    endfunction

    function void drop_command();
      awaiting     = 1'b0;
      target_req   = frc_pkg::REQ_NONE;
      target_btn   = frc_pkg::BTN_NONE;
      resends_used = '0;
      tick_count   = '0;
    endfunction

    function bit is_slow(logic [3:0] s);
      return s == frc_pkg::ST_SLOW_IN || s == frc_pkg::ST_SLOW_OUT;
    endfunction

    function bit is_mid(logic [3:0] s);
      return s == frc_pkg::ST_MID_IN || s == frc_pkg::ST_MID_OUT;
    endfunction

    function bit is_fast(logic [3:0] s);
      return s == frc_pkg::ST_FAST_IN || s == frc_pkg::ST_FAST_OUT;
    endfunction

    function void set_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        frc_pkg::CFG_FAN_ADDRESS:   addr = data;
        frc_pkg::CFG_RETRY_LIMIT:   retry_max = data[3:0];
        frc_pkg::CFG_TIMEOUT_TICKS: tmo = data[15:0];
        default: ;
      endcase
    endfunction

    // Unknown status codes leave the decoded mode, speed and direction alone.
    function void redecode();
      if (last_status == frc_pkg::ST_OFF) begin
        cur_mode  = frc_pkg::FM_OFF;
        cur_speed = frc_pkg::SPD_NONE;
        cur_dir   = frc_pkg::DIR_NONE;
      end else if (last_status == frc_pkg::ST_SUMMER) begin
        cur_mode  = frc_pkg::FM_SUMMER;
        cur_speed = frc_pkg::SPD_SLOW;
        cur_dir   = frc_pkg::DIR_OUT;
      end else if (is_slow(last_status) || is_mid(last_status) || is_fast(last_status)) begin
        cur_mode  = frc_pkg::FM_INTERVAL;
        cur_dir   = last_status[0] ? frc_pkg::DIR_OUT : frc_pkg::DIR_IN;
        cur_speed = is_fast(last_status) ? frc_pkg::SPD_FAST :
                    (is_mid(last_status) ? frc_pkg::SPD_MIDDLE : frc_pkg::SPD_SLOW);
      end
    endfunction

    function bit status_confirms();
      case (target_req)
        frc_pkg::REQ_ON:     return last_status != frc_pkg::ST_OFF;
        frc_pkg::REQ_OFF:    return last_status == frc_pkg::ST_OFF;
        frc_pkg::REQ_SUMMER: return last_status == frc_pkg::ST_SUMMER;
        frc_pkg::REQ_SLOW:   return is_slow(last_status);
        frc_pkg::REQ_MIDDLE: return is_mid(last_status);
        frc_pkg::REQ_FAST:   return is_fast(last_status);
        default:             return 1'b0;
      endcase
    endfunction

    function logic [2:0] seen_index(logic [3:0] b);
      case (b)
        frc_pkg::BTN_POWER:  return frc_pkg::SEEN_POWER;
        frc_pkg::BTN_SUMMER: return frc_pkg::SEEN_SUMMER;
        frc_pkg::BTN_PLUS:   return frc_pkg::SEEN_PLUS;
        frc_pkg::BTN_MINUS:  return frc_pkg::SEEN_MINUS;
        default:             return frc_pkg::SEEN_NONE;
      endcase
    endfunction

    function void note_request(frc_pkg::item_t it);
      frc_pkg::res_t r;
      logic [2:0]    want_req;
      logic [3:0]    want_btn;
      logic [3:0]    code;
      bit            fired;
      r         = '0;
      fired     = 1'b0;
      want_req  = frc_pkg::REQ_NONE;
      want_btn  = frc_pkg::BTN_NONE;
      code      = it.received_frame[3:0];
      n_requests++;
      case (it.mode)
        frc_pkg::MODE_FRAME: begin
          if (it.received_frame[23:4] == addr) begin
            if (code == frc_pkg::BTN_POWER || code == frc_pkg::BTN_MINUS ||
                code == frc_pkg::BTN_PLUS || code == frc_pkg::BTN_SUMMER)
              last_button = code;
            else
              last_status = code;
          end
          redecode();
        end
        frc_pkg::MODE_REQUEST: begin
          case (it.request)
            frc_pkg::REQ_ON: begin
              if (last_status == frc_pkg::ST_OFF) begin
                want_req = frc_pkg::REQ_ON;
                want_btn = frc_pkg::BTN_POWER;
              end
            end
            frc_pkg::REQ_OFF: begin
              if (last_status != frc_pkg::ST_OFF) begin
                want_req = frc_pkg::REQ_OFF;
                want_btn = frc_pkg::BTN_POWER;
              end
            end
            frc_pkg::REQ_SUMMER: begin
              if (last_status == frc_pkg::ST_OFF) begin
                r.event_res = frc_pkg::EV_NOT_POSS;
              end else if (last_status != frc_pkg::ST_SUMMER) begin
                want_req = frc_pkg::REQ_SUMMER;
                want_btn = frc_pkg::BTN_SUMMER;
              end
            end
            frc_pkg::REQ_SLOW: begin
              if (last_status == frc_pkg::ST_OFF) begin
                r.event_res = frc_pkg::EV_NOT_POSS;
              end else if (is_mid(last_status) || is_fast(last_status) ||
                           last_status == frc_pkg::ST_SUMMER) begin
                want_req = frc_pkg::REQ_SLOW;
                want_btn = frc_pkg::BTN_MINUS;
              end
            end
            frc_pkg::REQ_MIDDLE: begin
              // From summer, plus leads to slow rather than middle.
              if (last_status == frc_pkg::ST_OFF) begin
                r.event_res = frc_pkg::EV_NOT_POSS;
              end else if (last_status == frc_pkg::ST_SUMMER) begin
                want_req = frc_pkg::REQ_SLOW;
                want_btn = frc_pkg::BTN_PLUS;
              end else if (is_slow(last_status)) begin
                want_req = frc_pkg::REQ_MIDDLE;
                want_btn = frc_pkg::BTN_PLUS;
              end else if (is_fast(last_status)) begin
                want_req = frc_pkg::REQ_MIDDLE;
                want_btn = frc_pkg::BTN_MINUS;
              end
            end
            frc_pkg::REQ_FAST: begin
              if (last_status == frc_pkg::ST_OFF) begin
                r.event_res = frc_pkg::EV_NOT_POSS;
              end else if (is_mid(last_status) || is_slow(last_status) ||
                           last_status == frc_pkg::ST_SUMMER) begin
                want_req = frc_pkg::REQ_FAST;
                want_btn = frc_pkg::BTN_PLUS;
              end
            end
            default: ;
          endcase
          // A request taken while busy only swaps the pending command.
          if (want_req != frc_pkg::REQ_NONE) begin
            target_req = want_req;
            target_btn = want_btn;
            if (!awaiting) begin
              awaiting     = 1'b1;
              tick_count   = '0;
              resends_used = '0;
              r.transmit   = 1'b1;
              r.event_res  = frc_pkg::EV_STARTED;
            end
          end
        end
        frc_pkg::MODE_TICK: begin
          if (awaiting) begin
            if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
            if (tick_count >= tmo) begin
              fired      = 1'b1;
              tick_count = '0;
              if (resends_used < retry_max) begin
                resends_used = resends_used + 4'd1;
                r.transmit   = 1'b1;
              end else begin
                if (fail_total != 16'hFFFF) fail_total = fail_total + 16'd1;
                drop_command();
                r.event_res = frc_pkg::EV_FAILED;
              end
            end
          end
        end
        default: ;
      endcase
      // A timeout on this step suppresses the confirmation check.
      if ((it.mode == frc_pkg::MODE_TICK || it.mode == frc_pkg::MODE_FRAME) && awaiting &&
          !fired && r.event_res == frc_pkg::EV_NONE && status_confirms()) begin
        drop_command();
        r.event_res = frc_pkg::EV_DONE;
      end
      if (r.transmit) r.transmit_frame = {addr, target_btn};
      r.fan_mode      = cur_mode;
      r.fan_speed     = cur_speed;
      r.fan_direction = cur_dir;
      r.button_seen   = seen_index(last_button);
      r.failure_count = fail_total;
      r.busy_res      = awaiting;
      if (r.transmit) n_sent++;
      if (r.event_res == frc_pkg::EV_DONE) n_done++;
      if (r.event_res == frc_pkg::EV_FAILED) n_failed++;
      if (r.event_res == frc_pkg::EV_NOT_POSS) n_refused++;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      if (mismatches < PRINT_LIMIT)
        $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                 checked, what, got, want);
      mismatches++;
    endtask

    task check_result(frc_pkg::res_t got);
      frc_pkg::res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", 24'(got.event_res),
                        24'(frc_pkg::EV_NONE));
        return;
      end
      want = expected_q.pop_front();
      if (got.transmit !== want.transmit)
        report_mismatch("transmit", 24'(got.transmit), 24'(want.transmit));
      if (got.transmit_frame !== want.transmit_frame)
        report_mismatch("transmit_frame", got.transmit_frame, want.transmit_frame);
      if (got.event_res !== want.event_res)
        report_mismatch("event_res", 24'(got.event_res), 24'(want.event_res));
      if (got.fan_mode !== want.fan_mode)
        report_mismatch("fan_mode", 24'(got.fan_mode), 24'(want.fan_mode));
      if (got.fan_speed !== want.fan_speed)
        report_mismatch("fan_speed", 24'(got.fan_speed), 24'(want.fan_speed));
      if (got.fan_direction !== want.fan_direction)
        report_mismatch("fan_direction", 24'(got.fan_direction), 24'(want.fan_direction));
      if (got.button_seen !== want.button_seen)
        report_mismatch("button_seen", 24'(got.button_seen), 24'(want.button_seen));
      if (got.failure_count !== want.failure_count)
        report_mismatch("failure_count", 24'(got.failure_count), 24'(want.failure_count));
      if (got.busy_res !== want.busy_res)
        report_mismatch("busy_res", 24'(got.busy_res), 24'(want.busy_res));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [23:0] in_received_frame;
  logic [2:0]  in_request;
  logic        out_valid;
  logic        out_ready;
  logic        out_transmit;
  logic [23:0] out_transmit_frame;
  logic [2:0]  out_event_res;
  logic [1:0]  out_fan_mode;
  logic [1:0]  out_fan_speed;
  logic [1:0]  out_fan_direction;
  logic [2:0]  out_button_seen;
  logic [15:0] out_failure_count;
  logic        out_busy_res;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  fan_cmd_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  fan_remote_command_retry_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_received_frame  (in_received_frame),
    .in_request         (in_request),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_transmit       (out_transmit),
    .out_transmit_frame (out_transmit_frame),
    .out_event_res      (out_event_res),
    .out_fan_mode       (out_fan_mode),
    .out_fan_speed      (out_fan_speed),
    .out_fan_direction  (out_fan_direction),
    .out_button_seen    (out_button_seen),
    .out_failure_count  (out_failure_count),
    .out_busy_res       (out_busy_res),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: check what was taken at this edge, then pick next cycle's ready.
  initial begin
    frc_pkg::res_t got;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_transmit, out_transmit_frame, out_event_res, out_fan_mode,
               out_fan_speed, out_fan_direction, out_button_seen,
               out_failure_count, out_busy_res};
        tracker.check_result(got);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic frc_pkg::item_t make_item(logic [1:0] m, logic [23:0] f,
                                               logic [2:0] q);
    frc_pkg::item_t it;
    it.mode           = m;
    it.received_frame = f;
    it.request        = q;
    return it;
  endfunction

  // Most frames carry the programmed address so that codes actually land.
  function automatic frc_pkg::item_t random_item();
    frc_pkg::item_t it;
    int             pick;
    it.received_frame = 24'($urandom_range(24'hFFFFFF, 0));
    it.request        = 3'($urandom_range(7, 0));
    pick              = $urandom_range(99);
    if (pick < 40)
      it.mode = frc_pkg::MODE_TICK;
    else if (pick < 72)
      it.mode = frc_pkg::MODE_FRAME;
    else if (pick < 96)
      it.mode = frc_pkg::MODE_REQUEST;
    else
      it.mode = MODE_UNUSED;
    if (it.mode == frc_pkg::MODE_FRAME && $urandom_range(99) < 85)
      it.received_frame[23:4] = tracker.addr;
    return it;
  endfunction

  task automatic send_item(frc_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_received_frame <= it.received_frame;
    in_request        <= it.request;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(it);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // Stop offering requests and let every pending result come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(logic [19:0] a, logic [3:0] rl, logic [15:0] tt);
    cfg_write_en <= 1'b1;
    cfg_index    <= frc_pkg::CFG_FAN_ADDRESS;
    cfg_data     <= a;
    @(posedge clk);
    tracker.set_reg(frc_pkg::CFG_FAN_ADDRESS, a);
    cfg_index    <= frc_pkg::CFG_RETRY_LIMIT;
    cfg_data     <= {16'd0, rl};
    @(posedge clk);
    tracker.set_reg(frc_pkg::CFG_RETRY_LIMIT, {16'd0, rl});
    cfg_index    <= frc_pkg::CFG_TIMEOUT_TICKS;
    cfg_data     <= {4'd0, tt};
    @(posedge clk);
    tracker.set_reg(frc_pkg::CFG_TIMEOUT_TICKS, {4'd0, tt});
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_idle_profile(int p);
    case (p % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 68;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 68;
      end
      default: begin
        send_idle_pct  = 22;
        recv_stall_pct = 22;
      end
    endcase
  endtask

  initial begin
    frc_pkg::item_t directed_q[$];
    logic [19:0]    a;
    logic [19:0]    na;
    logic [3:0]     rl;
    logic [15:0]    tt;
    tracker = new();
    a  = frc_pkg::FAN_ADDRESS_RST;
    na = frc_pkg::FAN_ADDRESS_RST ^ 20'h00001;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_mode           <= frc_pkg::MODE_TICK;
    in_received_frame <= '0;
    in_request        <= frc_pkg::REQ_NONE;
    cfg_write_en      <= 1'b0;
    cfg_index         <= frc_pkg::CFG_FAN_ADDRESS;
    cfg_data          <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass under the reset register values.
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'hFFFFFF, frc_pkg::REQ_SLOW));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, REQ_UNUSED));
    directed_q.push_back(make_item(MODE_UNUSED, 24'hFFFFFF, REQ_UNUSED));
    directed_q.push_back(make_item(frc_pkg::MODE_TICK, 24'h000000, frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {na, frc_pkg::ST_SLOW_IN},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::BTN_POWER},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_ON));
    directed_q.push_back(make_item(frc_pkg::MODE_TICK, 24'h000000, frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, ST_UNKNOWN}, frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_SUMMER},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_MIDDLE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_FAST));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_SLOW_OUT},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_FAST_IN},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::BTN_SUMMER},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::BTN_PLUS},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::BTN_MINUS},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_MIDDLE));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_MID_OUT},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_MIDDLE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_SUMMER));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_SUMMER},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_SLOW));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_SLOW_IN},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_FAST));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_FAST_OUT},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_OFF));
    directed_q.push_back(make_item(frc_pkg::MODE_FRAME, {a, frc_pkg::ST_OFF},
                                   frc_pkg::REQ_NONE));
    directed_q.push_back(make_item(frc_pkg::MODE_REQUEST, 24'h000000, frc_pkg::REQ_ON));

    set_idle_profile(0);
    foreach (directed_q[i]) send_item(directed_q[i]);
    run_random(FIRST_ITEMS);

    for (int p = 1; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        1: begin
          a  = 20'h00000;
          rl = 4'd0;
          tt = 16'd1;
        end
        2: begin
          a  = 20'hFFFFF;
          rl = 4'd15;
          tt = 16'd3;
        end
        3: begin
          a  = 20'($urandom_range(20'hFFFFF, 0));
          rl = 4'($urandom_range(15, 0));
          tt = 16'($urandom_range(12, 1));
        end
        4: begin
          a  = 20'($urandom_range(20'hFFFFF, 0));
          rl = 4'($urandom_range(15, 0));
          tt = 16'hFFFF;
        end
        5: begin
          a  = 20'($urandom_range(20'hFFFFF, 0));
          rl = 4'd2;
          tt = 16'd2;
        end
        default: begin
          a  = 20'($urandom_range(20'hFFFFF, 0));
          rl = 4'($urandom_range(15, 0));
          tt = 16'($urandom_range(30, 1));
        end
      endcase
      program_regs(a, rl, tt);
      set_idle_profile(p);
      // Long result-side hold-off while requests keep coming, to back up the pipe.
      if (p == 4) hold_left = HOLD_CYCLES;
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (6) @(posedge clk);

    $display("Covered %0d requests over %0d register settings and four idle patterns.",
             tracker.n_requests, NUM_PHASES);
    $display("Commands: %0d sent, %0d confirmed, %0d failed, %0d refused; %0d mismatches.",
             tracker.n_sent, tracker.n_done, tracker.n_failed, tracker.n_refused,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
